// ----- rtl/core/gat_pkg.sv -----
// ----------------------------------------------------------------------------
// gat_pkg
// Shared types and codes of the graph adjacency table: operation and status
// codes, the command passed from front to back, and the result item.
// ----------------------------------------------------------------------------
package gat_pkg;

    // input function codes
    localparam logic [2:0] FN_ADD   = 3'd0;
    localparam logic [2:0] FN_LIST  = 3'd1;
    localparam logic [2:0] FN_COUNT = 3'd2;
    localparam logic [2:0] FN_CHECK = 3'd3;
    localparam logic [2:0] FN_CLEAR = 3'd4;

    // field widths fixed by the interface
    localparam int VTX_W   = 8;
    localparam int NB_W    = 4;
    localparam int EC_W    = 8;
    localparam int NV_W    = 5;

    // queue depths between the parts
    localparam int CMD_DEPTH = 2;
    localparam int RES_DEPTH = 4;
    localparam int RES_CW    = $clog2(RES_DEPTH + 1);

    // result status
    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_FULL    = 2'd2,
        ST_EMPTY   = 2'd3
    } status_t;

    // classified operation
    typedef enum logic [2:0] {
        OP_ADD,
        OP_LIST,
        OP_COUNT,
        OP_CHECK,
        OP_CLEAR,
        OP_REJECT
    } op_t;

    // back part sequencer states
    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DECIDE,
        BK_WRITE2,
        BK_STREAM
    } bk_state_t;

    // command from front to back
    typedef struct packed {
        op_t              op;
        logic [VTX_W-1:0] src;
        logic [VTX_W-1:0] dst;
    } cmd_t;

    // one result item
    typedef struct packed {
        status_t          status;
        logic [NB_W-1:0]  neighbor;
        logic [EC_W-1:0]  edge_count;
        logic [NV_W-1:0]  vertex_count;
        logic             exists;
        logic             last;
    } res_t;

endpackage

// ----- rtl/core/graph_adjacency_table.sv -----
// ----------------------------------------------------------------------------
// graph_adjacency_table
// Undirected graph store with a bounded neighbour list per vertex.
// ----------------------------------------------------------------------------
// Items enter through a queue-style push/full port and results leave through
// a queue-style empty/pop port. The front checks vertex indices and queues a
// command (two entries); the back works one command at a time into a result
// queue of four entries. Count, check, clear and rejected items are answered
// from idle; an add does a length lookup and a first and second append, or
// stops at the decision when a full list turns it away; a listing of n
// neighbours does a length lookup, a decision, n reads on the store's single
// read port and the landing of the last read, one result per cycle while the
// result queue has room, or stops at the decision for an empty list. All
// steps but the lookup and second append wait for result queue room.
// Per-vertex valid bits clear lists at once; no clearing pass follows reset.
// The user writes the vertex count through cfg_valid/cfg_ready only while
// idle, which the block does not enforce. Values above MAX_VERTICES saturate.
// ----------------------------------------------------------------------------
module graph_adjacency_table
    import gat_pkg::*;
#(
    parameter int MAX_VERTICES = 16,
    parameter int MAX_DEGREE   = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  logic [2:0]       func,
    input  logic [VTX_W-1:0] src_vertex,
    input  logic [VTX_W-1:0] dest_vertex,
    output logic             empty,
    input  logic             pop,
    output logic [1:0]       status,
    output logic [NB_W-1:0]  neighbor,
    output logic [EC_W-1:0]  edge_count,
    output logic [NV_W-1:0]  vertex_count,
    output logic             exists,
    output logic             last,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [NV_W-1:0]  num_vertices
);

    logic [NV_W-1:0]   nv_reg;
    logic [NV_W-1:0]   nv_next;
    logic              cmd_push;
    cmd_t              cmd_in;
    logic              cmd_full;
    logic              cmd_empty;
    logic              cmd_pop;
    cmd_t              cmd_head;
    logic              res_push;
    res_t              res_in;
    logic              res_full;
    logic [RES_CW-1:0] res_count;
    res_t              res_head;

    // vertex count register, saturated on write
    assign cfg_ready = 1'b1;
    assign nv_next   = (32'(num_vertices) > MAX_VERTICES) ? NV_W'(MAX_VERTICES)
                                                           : num_vertices;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nv_reg <= (MAX_VERTICES < 16) ? NV_W'(MAX_VERTICES) : NV_W'(16);
        end
        else if (cfg_valid && cfg_ready)
        begin
            nv_reg <= nv_next;
        end
    end

    // front: classify accepted items
    gat_front u_front (
        .accept      (push && !full),
        .func        (func),
        .src_vertex  (src_vertex),
        .dest_vertex (dest_vertex),
        .nv          (nv_reg),
        .cmd_push    (cmd_push),
        .cmd         (cmd_in)
    );

    // command queue between front and back
    gat_queue #(
        .WIDTH ($bits(cmd_t)),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (cmd_push),
        .push_data (cmd_in),
        .full      (cmd_full),
        .pop       (cmd_pop),
        .pop_data  (cmd_head),
        .empty     (cmd_empty),
        .count     ()
    );

    assign full = cmd_full;

    // back: carry out commands
    gat_back #(
        .MAX_VERTICES (MAX_VERTICES),
        .MAX_DEGREE   (MAX_DEGREE)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_empty (cmd_empty),
        .cmd       (cmd_head),
        .cmd_pop   (cmd_pop),
        .nv        (nv_reg),
        .res_count (res_count),
        .res_push  (res_push),
        .res_data  (res_in)
    );

    // result queue
    gat_queue #(
        .WIDTH ($bits(res_t)),
        .DEPTH (RES_DEPTH)
    ) u_res_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_push),
        .push_data (res_in),
        .full      (res_full),
        .pop       (pop),
        .pop_data  (res_head),
        .empty     (empty),
        .count     (res_count)
    );

    // result fields
    assign status       = res_head.status;
    assign neighbor     = res_head.neighbor;
    assign edge_count   = res_head.edge_count;
    assign vertex_count = res_head.vertex_count;
    assign exists       = res_head.exists;
    assign last         = res_head.last;

`ifndef SYNTHESIS
    // the back never pushes into a full result queue
    assert property (@(posedge clk) disable iff (!rst_n) res_push |-> !res_full)
        else $error("result pushed into full queue");

    // the back never takes a command that is not there
    assert property (@(posedge clk) disable iff (!rst_n) cmd_pop |-> !cmd_empty)
        else $error("command popped from empty queue");

    // the vertex count stays within the configured maximum
    assert property (@(posedge clk) disable iff (!rst_n)
                     (cfg_valid && cfg_ready) |=> (32'(nv_reg) <= MAX_VERTICES))
        else $error("vertex count above maximum");
`endif

endmodule

// ----- rtl/core/gat_queue.sv -----
// ----------------------------------------------------------------------------
// gat_queue
// Small first-in first-out queue of packed items with a fill count.
// ----------------------------------------------------------------------------
module gat_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    input  logic [WIDTH-1:0]             push_data,
    output logic                         full,
    input  logic                         pop,
    output logic [WIDTH-1:0]             pop_data,
    output logic                         empty,
    output logic [$clog2(DEPTH+1)-1:0]   count
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] data_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg;
    logic [PW-1:0]    rd_ptr_next;
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_next;
    logic             do_push;
    logic             do_pop;

    assign full     = (count_reg == CW'(DEPTH));
    assign empty    = (count_reg == '0);
    assign count    = count_reg;
    assign pop_data = data_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // item storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            data_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ----- rtl/core/gat_front.sv -----
// ----------------------------------------------------------------------------
// gat_front
// Front part: checks vertex indices against the vertex count and turns each
// accepted item into a command for the back part; unknown codes are dropped.
// ----------------------------------------------------------------------------
module gat_front
    import gat_pkg::*;
(
    input  logic             accept,
    input  logic [2:0]       func,
    input  logic [VTX_W-1:0] src_vertex,
    input  logic [VTX_W-1:0] dest_vertex,
    input  logic [NV_W-1:0]  nv,
    output logic             cmd_push,
    output cmd_t             cmd
);

    logic src_ok;
    logic dst_ok;

    // index valid when non-negative and below the vertex count
    assign src_ok = !src_vertex[VTX_W-1] && (src_vertex < VTX_W'(nv));
    assign dst_ok = !dest_vertex[VTX_W-1] && (dest_vertex < VTX_W'(nv));

    // classify the item
    always_comb
    begin
        cmd.src  = src_vertex;
        cmd.dst  = dest_vertex;
        cmd.op   = OP_REJECT;
        cmd_push = accept;
        unique case (func)
            FN_ADD:   cmd.op = (src_ok && dst_ok) ? OP_ADD : OP_REJECT;
            FN_LIST:  cmd.op = src_ok ? OP_LIST : OP_REJECT;
            FN_COUNT: cmd.op = OP_COUNT;
            FN_CHECK: cmd.op = src_ok ? OP_CHECK : OP_REJECT;
            FN_CLEAR: cmd.op = OP_CLEAR;
            default:  cmd_push = 1'b0;
        endcase
    end

endmodule

// ----- rtl/core/gat_back.sv -----
// ----------------------------------------------------------------------------
// gat_back
// Back part: holds the list lengths and the neighbour store, carries out one
// command at a time and streams neighbour lists into the result queue.
// ----------------------------------------------------------------------------
module gat_back
    import gat_pkg::*;
#(
    parameter int MAX_VERTICES = 16,
    parameter int MAX_DEGREE   = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_empty,
    input  cmd_t              cmd,
    output logic              cmd_pop,
    input  logic [NV_W-1:0]   nv,
    input  logic [RES_CW-1:0] res_count,
    output logic              res_push,
    output res_t              res_data
);

    localparam int VW  = $clog2(MAX_VERTICES);
    localparam int DW  = $clog2(MAX_DEGREE);
    localparam int LW  = $clog2(MAX_DEGREE + 1);
    localparam int AW  = VW + DW;
    localparam int SD  = MAX_VERTICES << DW;
    localparam int ETW = $clog2(MAX_VERTICES * MAX_DEGREE + 1);

    bk_state_t         state_reg;
    bk_state_t         state_next;
    cmd_t              cmd_reg;
    cmd_t              cmd_next;
    logic [LW-1:0]     len_mem [MAX_VERTICES];
    logic [VW-1:0]     st_mem [SD];
    logic [MAX_VERTICES-1:0] len_valid_reg;
    logic [LW-1:0]     len_a_reg;
    logic [LW-1:0]     len_b_reg;
    logic              vld_a_reg;
    logic              vld_b_reg;
    logic [VW-1:0]     st_q_reg;
    logic [DW-1:0]     slot_reg;
    logic [DW-1:0]     slot_next;
    logic              pend_reg;
    logic              pend_next;
    logic              pend_last_reg;
    logic              pend_last_next;
    logic [ETW-1:0]    total_reg;

    logic              len_rd;
    logic              len_we;
    logic [VW-1:0]     len_waddr;
    logic [LW-1:0]     len_wdata;
    logic              st_we;
    logic [AW-1:0]     st_waddr;
    logic [VW-1:0]     st_wdata;
    logic              st_rd;
    logic              clear_all;
    logic              total_add;
    logic [LW-1:0]     len_a;
    logic [LW-1:0]     len_b;
    logic [VW-1:0]     src_idx;
    logic [VW-1:0]     dst_idx;
    logic              self_loop;
    logic              list_full;
    logic              room;
    logic              stream_room;

    assign src_idx   = cmd_reg.src[VW-1:0];
    assign dst_idx   = cmd_reg.dst[VW-1:0];
    assign len_a     = vld_a_reg ? len_a_reg : '0;
    assign len_b     = vld_b_reg ? len_b_reg : '0;
    assign self_loop = (src_idx == dst_idx);
    assign room      = (res_count < RES_CW'(RES_DEPTH));
    assign stream_room = (({1'b0, res_count} + (RES_CW+1)'(pend_reg))
                          < (RES_CW+1)'(RES_DEPTH));

    // rejection when either list would overflow; a self-loop needs two slots
    always_comb
    begin
        if (self_loop)
        begin
            list_full = ({1'b0, len_a} + (LW+1)'(2)) > (LW+1)'(MAX_DEGREE);
        end
        else
        begin
            list_full = (({1'b0, len_a} + (LW+1)'(1)) > (LW+1)'(MAX_DEGREE))
                     || (({1'b0, len_b} + (LW+1)'(1)) > (LW+1)'(MAX_DEGREE));
        end
    end

    // sequencer: next state and controls
    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        slot_next      = slot_reg;
        pend_next      = 1'b0;
        pend_last_next = pend_last_reg;
        cmd_pop        = 1'b0;
        len_rd         = 1'b0;
        len_we         = 1'b0;
        len_waddr      = src_idx;
        len_wdata      = '0;
        st_we          = 1'b0;
        st_waddr       = {src_idx, slot_reg};
        st_wdata       = dst_idx;
        st_rd          = 1'b0;
        clear_all      = 1'b0;
        total_add      = 1'b0;
        res_push       = 1'b0;
        res_data       = '{status: ST_OK, neighbor: '0, edge_count: '0,
                           vertex_count: '0, exists: 1'b0, last: 1'b1};

        // pending neighbour read lands in the result queue
        if (pend_reg)
        begin
            res_push          = 1'b1;
            res_data.neighbor = NB_W'(st_q_reg);
            res_data.last     = pend_last_reg;
        end

        unique case (state_reg)
            BK_IDLE:
            begin
                if (!cmd_empty && !pend_reg)
                begin
                    unique case (cmd.op) inside
                        OP_ADD, OP_LIST:
                        begin
                            cmd_pop    = 1'b1;
                            cmd_next   = cmd;
                            len_rd     = 1'b1;
                            state_next = BK_DECIDE;
                        end
                        OP_COUNT:
                        begin
                            if (room)
                            begin
                                cmd_pop  = 1'b1;
                                res_push = 1'b1;
                                res_data.edge_count   = EC_W'(total_reg[ETW-1:1]);
                                res_data.vertex_count = nv;
                            end
                        end
                        OP_CHECK:
                        begin
                            if (room)
                            begin
                                cmd_pop         = 1'b1;
                                res_push        = 1'b1;
                                res_data.exists = 1'b1;
                            end
                        end
                        OP_CLEAR:
                        begin
                            if (room)
                            begin
                                cmd_pop   = 1'b1;
                                res_push  = 1'b1;
                                clear_all = 1'b1;
                            end
                        end
                        OP_REJECT:
                        begin
                            if (room)
                            begin
                                cmd_pop         = 1'b1;
                                res_push        = 1'b1;
                                res_data.status = ST_INVALID;
                            end
                        end
                        default:
                        begin
                            cmd_pop = 1'b1;
                        end
                    endcase
                end
            end
            BK_DECIDE:
            begin
                if (room)
                begin
                    if (cmd_reg.op == OP_ADD)
                    begin
                        if (list_full)
                        begin
                            res_push        = 1'b1;
                            res_data.status = ST_FULL;
                            state_next      = BK_IDLE;
                        end
                        else
                        begin
                            // first end: append dst to the list of src
                            len_we     = 1'b1;
                            len_waddr  = src_idx;
                            len_wdata  = len_a + 1'b1;
                            st_we      = 1'b1;
                            st_waddr   = {src_idx, len_a[DW-1:0]};
                            st_wdata   = dst_idx;
                            slot_next  = self_loop ? DW'(len_a + 1'b1) : len_b[DW-1:0];
                            state_next = BK_WRITE2;
                        end
                    end
                    else if (len_a == '0)
                    begin
                        res_push        = 1'b1;
                        res_data.status = ST_EMPTY;
                        state_next      = BK_IDLE;
                    end
                    else
                    begin
                        slot_next  = DW'(len_a - 1'b1);
                        state_next = BK_STREAM;
                    end
                end
            end
            BK_WRITE2:
            begin
                // second end: append src to the list of dst
                len_we     = 1'b1;
                len_waddr  = dst_idx;
                len_wdata  = LW'(slot_reg) + 1'b1;
                st_we      = 1'b1;
                st_waddr   = {dst_idx, slot_reg};
                st_wdata   = src_idx;
                total_add  = 1'b1;
                res_push   = 1'b1;
                state_next = BK_IDLE;
            end
            BK_STREAM:
            begin
                // newest first, one store read per cycle while the result queue has room
                if (stream_room)
                begin
                    st_rd          = 1'b1;
                    pend_next      = 1'b1;
                    pend_last_next = (slot_reg == '0);
                    slot_next      = slot_reg - 1'b1;
                    if (slot_reg == '0)
                    begin
                        state_next = BK_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            pend_reg      <= 1'b0;
            len_valid_reg <= '0;
            total_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
            if (clear_all)
            begin
                len_valid_reg <= '0;
                total_reg     <= '0;
            end
            else
            begin
                if (len_we)
                begin
                    len_valid_reg[len_waddr] <= 1'b1;
                end
                if (total_add)
                begin
                    total_reg <= total_reg + ETW'(2);
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        slot_reg      <= slot_next;
        pend_last_reg <= pend_last_next;
    end

    // list length memory, two registered read ports
    always_ff @(posedge clk)
    begin
        if (len_we)
        begin
            len_mem[len_waddr] <= len_wdata;
        end
        if (len_rd)
        begin
            len_a_reg <= len_mem[cmd.src[VW-1:0]];
            len_b_reg <= len_mem[cmd.dst[VW-1:0]];
            vld_a_reg <= len_valid_reg[cmd.src[VW-1:0]];
            vld_b_reg <= len_valid_reg[cmd.dst[VW-1:0]];
        end
    end

    // neighbour store memory
    always_ff @(posedge clk)
    begin
        if (st_we)
        begin
            st_mem[st_waddr] <= st_wdata;
        end
        if (st_rd)
        begin
            st_q_reg <= st_mem[{src_idx, slot_reg}];
        end
    end

endmodule
